// ===== src/stfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfc_pkg
// Shared types, codes and constants of the segmented transfer controller.
// ----------------------------------------------------------------------------
`default_nettype none
package stfc_pkg;

    localparam int unsigned SECTION_BYTES   = 6;
    localparam int unsigned WINDOW_SECTIONS = 32;
    localparam logic [7:0]  TIMEOUT_RESET   = 8'd30;
    localparam logic [7:0]  TICKS_IDLE      = 8'd50;

    typedef enum logic [2:0] {
        OP_START_SEND = 3'd0,
        OP_START_RECV = 3'd1,
        OP_DATA       = 3'd2,
        OP_REPORT     = 3'd3,
        OP_TICK       = 3'd4,
        OP_ABORT      = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        RPT_NEXT   = 3'd0,
        RPT_WAIT   = 3'd1,
        RPT_RESEND = 3'd2,
        RPT_DONE   = 3'd3,
        RPT_ABORT  = 3'd4
    } rpt_t;

    typedef enum logic [3:0] {
        MSG_OK          = 4'd0,
        MSG_REJ_BUSY    = 4'd1,
        MSG_REJ_BAD     = 4'd2,
        MSG_SEND_SEC    = 4'd3,
        MSG_STORE_SEC   = 4'd4,
        MSG_COMMIT      = 4'd5,
        MSG_DONE        = 4'd6,
        MSG_SEND_NEXT   = 4'd7,
        MSG_RESEND      = 4'd8,
        MSG_ABORT       = 4'd9,
        MSG_TO_REPORT   = 4'd10,
        MSG_RESTORE     = 4'd11,
        MSG_TO_ALARM    = 4'd12,
        MSG_OVERRUN     = 4'd13
    } msg_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEND = 2'd1,
        MODE_RECV = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EMIT,
        ST_WINDOW
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the input item
        logic apply;     // run the single-step update and build the result list
        logic win_start; // begin a send window
        logic win_step;  // emit one section of the window
        logic pop;       // advance to next queued result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic has_queue; // queued results remain
        logic win_go;    // decision says a window follows
        logic win_more;  // window has more sections after this one
    } sts_t;

    typedef struct packed {
        logic [47:0] payload_out;
        logic [2:0]  byte_count;
        logic [15:0] byte_offset;
        logic [4:0]  section_index;
        logic [3:0]  reply_net_id;
        logic [3:0]  msg_kind;
    } res_t;

endpackage
`default_nettype wire

// ===== src/stfc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfc_datapath
// Session state, per-item update and section generation.
// ----------------------------------------------------------------------------
`default_nettype none
module stfc_datapath
    import stfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    input  wire logic [7:0]  timeout_ticks,
    input  wire logic [83:0] in_data,
    output res_t             res,
    output logic             res_last
);
    logic [2:0]  op_reg;
    logic [3:0]  net_reg;
    logic [15:0] size_reg;
    logic [7:0]  seq_reg;
    logic [47:0] pay_reg;
    logic [2:0]  code_reg;

    mode_t       mode_reg, mode_next;
    logic [3:0]  peer_reg, peer_next;
    logic [15:0] blk_reg, blk_next;
    logic [16:0] sent_reg, sent_next;
    logic [7:0]  winb_reg, winb_next;
    logic [5:0]  eseq_reg, eseq_next;
    logic [16:0] recv_reg, recv_next;
    logic        serr_reg, serr_next;
    logic [7:0]  ticks_reg, ticks_next;

    // queue of up to three short results
    res_t        q_reg [3];
    res_t        q_next [3];
    logic [1:0]  qn_reg, qn_next, qp_reg, qp_next;
    logic        wgo_reg, wgo_next;
    logic [4:0]  widx_reg, widx_next;
    logic        wlast_reg, wlast_next;

    logic [16:0] step_sum, rcv_sum, sec_end;
    logic [17:0] rcv_cnt;
    logic        sec_fits;

    function automatic res_t mk(input msg_t k, input logic [3:0] n);
        res_t r;
        r = '0;
        r.msg_kind = k;
        r.reply_net_id = n;
        return r;
    endfunction

    assign step_sum = recv_reg + 17'(SECTION_BYTES);
    assign sec_end  = sent_reg + 17'(SECTION_BYTES);
    assign sec_fits = sec_end < {1'b0, blk_reg};
    assign rcv_sum  = 17'(SECTION_BYTES);
    assign rcv_cnt  = 18'(blk_reg) + 18'(rcv_sum) - 18'(step_sum);

    always_comb
    begin
        logic [5:0] eseq_inc;
        mode_next  = mode_reg;
        peer_next  = peer_reg;
        blk_next   = blk_reg;
        sent_next  = sent_reg;
        winb_next  = winb_reg;
        eseq_next  = eseq_reg;
        recv_next  = recv_reg;
        serr_next  = serr_reg;
        ticks_next = ticks_reg;
        q_next     = q_reg;
        qn_next    = qn_reg;
        qp_next    = qp_reg;
        wgo_next   = wgo_reg;
        widx_next  = widx_reg;
        wlast_next = wlast_reg;
        eseq_inc   = eseq_reg + 6'd1;

        if (cmd.pop) qp_next = qp_reg + 2'd1;

        if (cmd.apply)
        begin
            qn_next  = 2'd0;
            qp_next  = 2'd0;
            wgo_next = 1'b0;
            unique case (op_reg)
                OP_START_SEND, OP_START_RECV:
                begin
                    qn_next = 2'd1;
                    if (mode_reg != MODE_IDLE)
                        q_next[0] = mk(MSG_REJ_BUSY, net_reg);
                    else if (size_reg == '0)
                        q_next[0] = mk(MSG_REJ_BAD, net_reg);
                    else
                    begin
                        q_next[0] = mk(MSG_OK, net_reg);
                        peer_next = net_reg;
                        blk_next  = size_reg;
                        if (op_reg == OP_START_SEND)
                        begin
                            mode_next = MODE_SEND;
                            sent_next = '0;
                            wgo_next  = 1'b1;
                        end
                        else
                        begin
                            mode_next  = MODE_RECV;
                            recv_next  = '0;
                            ticks_next = timeout_ticks;
                        end
                    end
                end
                OP_DATA:
                begin
                    if (mode_reg != MODE_RECV)
                    begin
                        q_next[0] = mk(MSG_ABORT, net_reg);
                        qn_next   = 2'd1;
                    end
                    else
                    begin
                        serr_next = serr_reg | (8'(eseq_reg) != seq_reg);
                        recv_next = step_sum;
                        eseq_next = eseq_inc;
                        q_next[0] = mk(MSG_STORE_SEC, net_reg);
                        q_next[0].byte_offset = recv_reg[15:0];
                        q_next[0].payload_out = pay_reg;
                        if (step_sum >= {1'b0, blk_reg})
                        begin
                            q_next[0].byte_count = rcv_cnt[2:0];
                            if (!serr_next)
                            begin
                                q_next[1] = mk(MSG_COMMIT, net_reg);
                                q_next[2] = mk(MSG_DONE, net_reg);
                                qn_next   = 2'd3;
                                mode_next = MODE_IDLE; peer_next = '0; blk_next = '0;
                                sent_next = '0; winb_next = '0; eseq_next = '0;
                                recv_next = '0; serr_next = 1'b0;
                                ticks_next = TICKS_IDLE;
                            end
                            else
                            begin
                                // rewind by the incremented count
                                recv_next = (step_sum >= 17'(eseq_inc) * 17'(SECTION_BYTES))
                                    ? step_sum - 17'(eseq_inc) * 17'(SECTION_BYTES) : '0;
                                serr_next  = 1'b0;
                                eseq_next  = '0;
                                q_next[1]  = mk(MSG_RESEND, net_reg);
                                qn_next    = 2'd2;
                                ticks_next = timeout_ticks;
                            end
                        end
                        else
                        begin
                            q_next[0].byte_count = 3'(SECTION_BYTES);
                            qn_next = 2'd1;
                            if (32'(eseq_inc) == WINDOW_SECTIONS)
                            begin
                                qn_next = 2'd2;
                                if (!serr_next)
                                    q_next[1] = mk(MSG_SEND_NEXT, net_reg);
                                else
                                begin
                                    recv_next = (step_sum >= 17'(eseq_inc) * 17'(SECTION_BYTES))
                                        ? step_sum - 17'(eseq_inc) * 17'(SECTION_BYTES) : '0;
                                    serr_next = 1'b0;
                                    q_next[1] = mk(MSG_RESEND, net_reg);
                                end
                                eseq_next = '0;
                            end
                            ticks_next = timeout_ticks;
                        end
                    end
                end
                OP_REPORT:
                begin
                    if (mode_reg == MODE_SEND)
                    begin
                        unique case (code_reg)
                            RPT_NEXT, RPT_WAIT:
                            begin
                                if (sent_reg >= {1'b0, blk_reg})
                                begin
                                    q_next[0] = mk(MSG_OVERRUN, net_reg);
                                    qn_next   = 2'd1;
                                    mode_next = MODE_IDLE; peer_next = '0; blk_next = '0;
                                    sent_next = '0; winb_next = '0; eseq_next = '0;
                                    recv_next = '0; serr_next = 1'b0;
                                    ticks_next = TICKS_IDLE;
                                end
                                else if (code_reg == RPT_NEXT)
                                    wgo_next = 1'b1;
                                else
                                    ticks_next = timeout_ticks;
                            end
                            RPT_RESEND:
                            begin
                                sent_next = (17'(winb_reg) <= sent_reg)
                                    ? sent_reg - 17'(winb_reg) : '0;
                                wgo_next  = 1'b1;
                            end
                            RPT_DONE, RPT_ABORT:
                            begin
                                mode_next = MODE_IDLE; peer_next = '0; blk_next = '0;
                                sent_next = '0; winb_next = '0; eseq_next = '0;
                                recv_next = '0; serr_next = 1'b0;
                                ticks_next = TICKS_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end
                OP_TICK:
                begin
                    if (mode_reg != MODE_IDLE && ticks_reg != '0)
                    begin
                        ticks_next = ticks_reg - 8'd1;
                        if (ticks_reg == 8'd1)
                        begin
                            if (mode_reg == MODE_RECV)
                            begin
                                q_next[0] = mk(MSG_TO_REPORT, peer_reg);
                                q_next[1] = mk(MSG_RESTORE, peer_reg);
                                qn_next   = 2'd2;
                            end
                            else
                            begin
                                q_next[0] = mk(MSG_TO_ALARM, peer_reg);
                                qn_next   = 2'd1;
                            end
                            mode_next = MODE_IDLE; peer_next = '0; blk_next = '0;
                            sent_next = '0; winb_next = '0; eseq_next = '0;
                            recv_next = '0; serr_next = 1'b0;
                            ticks_next = TICKS_IDLE;
                        end
                    end
                end
                OP_ABORT:
                begin
                    if (mode_reg != MODE_IDLE)
                    begin
                        mode_next = MODE_IDLE; peer_next = '0; blk_next = '0;
                        sent_next = '0; winb_next = '0; eseq_next = '0;
                        recv_next = '0; serr_next = 1'b0;
                        ticks_next = TICKS_IDLE;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.win_start)
        begin
            winb_next  = '0;
            widx_next  = '0;
            wlast_next = 1'b0;
            ticks_next = timeout_ticks;
        end

        if (cmd.win_step)
        begin
            widx_next = widx_reg + 5'd1;
            if (sec_fits)
            begin
                sent_next  = sec_end;
                winb_next  = winb_reg + 8'(SECTION_BYTES);
                wlast_next = (32'(widx_reg) == WINDOW_SECTIONS - 1);
            end
            else
            begin
                winb_next  = winb_reg + ((blk_reg > sent_reg[15:0] && !sent_reg[16])
                             ? 8'(blk_reg - sent_reg[15:0]) : 8'd0);
                sent_next  = {1'b0, blk_reg};
                wlast_next = 1'b1;
            end
        end
    end

    // result mux
    always_comb
    begin
        res = '0;
        res_last = 1'b0;
        if (wgo_reg && qp_reg == qn_reg)
        begin
            res.msg_kind      = MSG_SEND_SEC;
            res.reply_net_id  = net_reg;
            res.section_index = widx_reg;
            res.byte_offset   = sent_reg[15:0];
            if (sec_fits)
                res.byte_count = 3'(SECTION_BYTES);
            else
                res.byte_count = (blk_reg > sent_reg[15:0] && !sent_reg[16])
                                 ? 3'(blk_reg - sent_reg[15:0]) : 3'd0;
            res_last = !sec_fits || (32'(widx_reg) == WINDOW_SECTIONS - 1);
        end
        else
        begin
            res = q_reg[qp_reg];
            res_last = !wgo_reg && (qp_reg + 2'd1 == qn_reg);
        end
    end

    assign sts.has_queue = qp_reg != qn_reg;
    assign sts.win_go    = wgo_reg;
    assign sts.win_more  = !wlast_next;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_data[2:0];
            net_reg  <= in_data[6:3];
            size_reg <= in_data[22:7];
            seq_reg  <= in_data[30:23];
            pay_reg  <= in_data[78:31];
            code_reg <= in_data[81:79];
        end
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            peer_reg  <= '0;
            blk_reg   <= '0;
            sent_reg  <= '0;
            winb_reg  <= '0;
            eseq_reg  <= '0;
            recv_reg  <= '0;
            serr_reg  <= 1'b0;
            ticks_reg <= TICKS_IDLE;
            qn_reg    <= '0;
            qp_reg    <= '0;
            wgo_reg   <= 1'b0;
            widx_reg  <= '0;
            wlast_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            peer_reg  <= peer_next;
            blk_reg   <= blk_next;
            sent_reg  <= sent_next;
            winb_reg  <= winb_next;
            eseq_reg  <= eseq_next;
            recv_reg  <= recv_next;
            serr_reg  <= serr_next;
            ticks_reg <= ticks_next;
            qn_reg    <= qn_next;
            qp_reg    <= qp_next;
            wgo_reg   <= wgo_next;
            widx_reg  <= widx_next;
            wlast_reg <= wlast_next;
        end
    end

    logic unused_ok;
    assign unused_ok = ^{rcv_sum, in_data[83:82], wlast_reg};
endmodule
`default_nettype wire

// ===== src/stfc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stfc_ctrl
// Sequencer: accept, decide, drain queued results, then walk the window.
// ----------------------------------------------------------------------------
`default_nettype none
module stfc_ctrl
    import stfc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_IDLE;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.has_queue)
                begin
                    out_valid = 1'b1;
                    if (out_ready) cmd.pop = 1'b1;
                end
                else if (sts.win_go)
                begin
                    cmd.win_start = 1'b1;
                    state_next    = ST_WINDOW;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_WINDOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.win_step = 1'b1;
                    if (!sts.win_more) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/segmented_transfer_flow_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_transfer_flow_control
// Session controller moving a byte block in 6-byte sections, 32 per window.
// ----------------------------------------------------------------------------
// One message is handled at a time. The session state is updated in the cycle
// after the accept cycle; then results go out one per cycle while the downstream
// side is ready: up to three short results, then, after a check for a following
// window, for a send window one section per cycle (up to 32). The window walk in
// the datapath is the longest part of a message. Results carry last on the final
// transfer of the message.
// Register 0 (byte address 0) holds the timeout reload value.
`default_nettype none
module segmented_transfer_flow_control
    import stfc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[2:0], net_id[6:3], total_size[22:7], seq_num[30:23], payload[78:31],
    // report_code[81:79], zero fill to 88 bits
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // msg_kind[3:0], reply_net_id[7:4], section_index[12:8], byte_offset[28:13],
    // byte_count[31:29], payload_out[79:32]
    output logic [79:0]      m_axis_tdata,
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    cmd_t       cmd;
    sts_t       sts;
    res_t       res;
    logic [7:0] timeout_reg;

    // configuration register: write on access phase, address 0 only
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (psel && penable && pwrite && paddr == 1'b0)
            timeout_reg <= pwdata[7:0];
    end
    assign prdata = (paddr == 1'b0) ? {24'd0, timeout_reg} : 32'd0;

    stfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    stfc_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .timeout_ticks (timeout_reg),
        .in_data       (s_axis_tdata[83:0]),
        .res           (res),
        .res_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {res.payload_out, res.byte_count, res.byte_offset,
                           res.section_index, res.reply_net_id, res.msg_kind};

    logic unused_ok;
    assign unused_ok = ^{s_axis_tdata[87:84], pwdata[31:8]};
endmodule
`default_nettype wire
